@@ hdl/dmlp_pkg.sv @@
// dmlp_pkg: shared types and constants of the dag label path block
// holds command codes, datapath operation codes and the status struct
// depends on nothing
`timescale 1ns / 1ps

package dmlp_pkg;

	// fixed field widths
	localparam int NODE_W   = 8;
	localparam int NODE_CAP = 256;
	localparam int COUNT_W  = 9;
	localparam int LETTER_W = 5;
	localparam int CMD_W    = 2;

	// input command codes
	localparam logic [CMD_W-1:0] CMD_SET_LETTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_EDGE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN        = 2'd2;

	// configuration register index
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

	// one datapath operation per cycle
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT,
		OP_CLR_DEG,
		OP_EDGE_RD,
		OP_DEG_LATCH,
		OP_DEG_INC,
		OP_I_ZERO,
		OP_Q_RD,
		OP_Q_PUSH,
		OP_HEAD_RD,
		OP_K_U,
		OP_K_DEC,
		OP_DP_START,
		OP_CLR_SCORE,
		OP_P_U,
		OP_P_S,
		OP_SCORE_LATCH,
		OP_SCORE_UPD,
		OP_NEXT_LETTER,
		OP_FINISH
	} op_t;

	// loop conditions reported to the controller
	typedef struct packed {
		logic edge_end;
		logic node_end;
		logic queue_end;
		logic head_end;
		logic cyclic;
		logic last_letter;
		logic out_free;
	} status_t;

endpackage

@@ hdl/dag_max_label_path.sv @@
// dag_max_label_path: top level with the configuration port
// depends on dmlp_pkg, dmlp_ctrl and dmlp_datapath
`timescale 1ns / 1ps

// Loads a directed graph one transaction per cycle while no run is in
// progress. A run transaction orders the graph with Kahn's method,
// then scores every letter in topological order. Every node visit rescans
// the whole edge store through its single read port. Before it finishes,
// a run waits for a previous result to drain. The result waits in
// an output register; load transactions are taken meanwhile.

module dag_max_label_path #(
	parameter int MAX_EDGES = 1024,
	parameter int ALPHABET  = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  node_a,
	input  logic [7:0]  node_b,
	input  logic [4:0]  letter,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        has_cycle,
	output logic [8:0]  best_count,
	output logic        edges_dropped
);

	logic [dmlp_pkg::COUNT_W-1:0] node_count_q;
	dmlp_pkg::status_t            status;
	dmlp_pkg::op_t                op;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == dmlp_pkg::REG_NODE_COUNT) ? {23'd0, node_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= dmlp_pkg::NODE_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == dmlp_pkg::REG_NODE_COUNT) begin
			node_count_q <= pwdata[dmlp_pkg::COUNT_W-1:0];
		end
	end

	dmlp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .command(command),
		.status(status), .in_ready(in_ready), .op(op)
	);

	dmlp_datapath #(.MAX_EDGES(MAX_EDGES), .ALPHABET(ALPHABET)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .cfg_nodes(node_count_q),
		.command(command), .node_a(node_a), .node_b(node_b), .letter(letter),
		.out_ready(out_ready), .status(status), .out_valid(out_valid),
		.has_cycle(has_cycle), .best_count(best_count), .edges_dropped(edges_dropped)
	);

endmodule

@@ hdl/dmlp_ram.sv @@
// dmlp_ram: generic one write port, one read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module dmlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/dmlp_ctrl.sv @@
// dmlp_ctrl: state machine that sequences load, ordering and scoring passes
// depends on dmlp_pkg for operation codes and the status struct
`timescale 1ns / 1ps

module dmlp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [dmlp_pkg::CMD_W-1:0]     command,
	input  dmlp_pkg::status_t              status,
	output logic                           in_ready,
	output dmlp_pkg::op_t                  op
);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_CLR_DEG, S_D_A, S_D_B, S_D_C, S_Q_A, S_Q_B,
		S_K_HEAD, S_K_U, S_K_EA, S_K_EB, S_K_EC,
		S_P_CLR, S_P_HEAD, S_P_U, S_P_S, S_P_EA, S_P_EB, S_P_EC, S_FIN
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and operation
	always_comb begin
		state_d = state_q;
		op      = dmlp_pkg::OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = dmlp_pkg::OP_LOAD;
					if (command == dmlp_pkg::CMD_RUN) state_d = S_INIT;
				end
			end
			S_INIT: begin
				op = dmlp_pkg::OP_INIT;
				state_d = S_CLR_DEG;
			end
			S_CLR_DEG: begin
				if (status.node_end) state_d = S_D_A;
				else op = dmlp_pkg::OP_CLR_DEG;
			end
			S_D_A: begin
				if (status.edge_end) begin
					op = dmlp_pkg::OP_I_ZERO;
					state_d = S_Q_A;
				end else begin
					op = dmlp_pkg::OP_EDGE_RD;
					state_d = S_D_B;
				end
			end
			S_D_B: begin
				op = dmlp_pkg::OP_DEG_LATCH;
				state_d = S_D_C;
			end
			S_D_C: begin
				op = dmlp_pkg::OP_DEG_INC;
				state_d = S_D_A;
			end
			S_Q_A: begin
				if (status.node_end) begin
					state_d = S_K_HEAD;
				end else begin
					op = dmlp_pkg::OP_Q_RD;
					state_d = S_Q_B;
				end
			end
			S_Q_B: begin
				op = dmlp_pkg::OP_Q_PUSH;
				state_d = S_Q_A;
			end
			S_K_HEAD: begin
				if (status.queue_end) begin
					if (status.cyclic) begin
						state_d = S_FIN;
					end else begin
						op = dmlp_pkg::OP_DP_START;
						state_d = S_P_CLR;
					end
				end else begin
					op = dmlp_pkg::OP_HEAD_RD;
					state_d = S_K_U;
				end
			end
			S_K_U: begin
				op = dmlp_pkg::OP_K_U;
				state_d = S_K_EA;
			end
			S_K_EA: begin
				if (status.edge_end) begin
					state_d = S_K_HEAD;
				end else begin
					op = dmlp_pkg::OP_EDGE_RD;
					state_d = S_K_EB;
				end
			end
			S_K_EB: begin
				op = dmlp_pkg::OP_DEG_LATCH;
				state_d = S_K_EC;
			end
			S_K_EC: begin
				op = dmlp_pkg::OP_K_DEC;
				state_d = S_K_EA;
			end
			S_P_CLR: begin
				if (status.node_end) state_d = S_P_HEAD;
				else op = dmlp_pkg::OP_CLR_SCORE;
			end
			S_P_HEAD: begin
				if (status.head_end) begin
					if (status.last_letter) begin
						state_d = S_FIN;
					end else begin
						op = dmlp_pkg::OP_NEXT_LETTER;
						state_d = S_P_CLR;
					end
				end else begin
					op = dmlp_pkg::OP_HEAD_RD;
					state_d = S_P_U;
				end
			end
			S_P_U: begin
				op = dmlp_pkg::OP_P_U;
				state_d = S_P_S;
			end
			S_P_S: begin
				op = dmlp_pkg::OP_P_S;
				state_d = S_P_EA;
			end
			S_P_EA: begin
				if (status.edge_end) begin
					state_d = S_P_HEAD;
				end else begin
					op = dmlp_pkg::OP_EDGE_RD;
					state_d = S_P_EB;
				end
			end
			S_P_EB: begin
				op = dmlp_pkg::OP_SCORE_LATCH;
				state_d = S_P_EC;
			end
			S_P_EC: begin
				op = dmlp_pkg::OP_SCORE_UPD;
				state_d = S_P_EA;
			end
			S_FIN: begin
				if (status.out_free) begin
					op = dmlp_pkg::OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/dmlp_datapath.sv @@
// dmlp_datapath: graph stores, counters and result register
// depends on dmlp_pkg and dmlp_ram
`timescale 1ns / 1ps

module dmlp_datapath #(
	parameter int MAX_EDGES = 1024,
	parameter int ALPHABET  = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dmlp_pkg::op_t                     op,
	input  logic [dmlp_pkg::COUNT_W-1:0]      cfg_nodes,
	input  logic [dmlp_pkg::CMD_W-1:0]        command,
	input  logic [dmlp_pkg::NODE_W-1:0]       node_a,
	input  logic [dmlp_pkg::NODE_W-1:0]       node_b,
	input  logic [dmlp_pkg::LETTER_W-1:0]     letter,
	input  logic                              out_ready,
	output dmlp_pkg::status_t                 status,
	output logic                              out_valid,
	output logic                              has_cycle,
	output logic [dmlp_pkg::COUNT_W-1:0]      best_count,
	output logic                              edges_dropped
);

	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW  = $clog2(ALPHABET);
	localparam int MW  = (CW > dmlp_pkg::LETTER_W) ? CW : dmlp_pkg::LETTER_W;
	localparam int NW  = dmlp_pkg::NODE_W;
	localparam int KW  = dmlp_pkg::COUNT_W;

	logic [KW-1:0] n_q, i_q, head_q, tail_q, su_q, best_q;
	logic [EW-1:0] e_q, etotal_q;
	logic [CW-1:0] c_q;
	logic [NW-1:0] u_q, dst_q;
	logic          ovf_q, vld_q, hit_q;

	// ram ports
	logic            edge_we;
	logic [2*NW-1:0] edge_rd;
	logic            let_we;
	logic [dmlp_pkg::LETTER_W-1:0] let_rd;
	logic            deg_we;
	logic [NW-1:0]   deg_waddr, deg_raddr;
	logic [EW-1:0]   deg_wdata, deg_rd;
	logic            topo_we;
	logic [NW-1:0]   topo_waddr, topo_wdata, topo_rd;
	logic            score_we;
	logic [NW-1:0]   score_waddr, score_raddr;
	logic [KW-1:0]   score_wdata, score_rd;

	logic          full, match;
	logic [KW-1:0] n_eff, su_d;
	logic [EW-1:0] deg_dec;

	assign full    = (etotal_q == EW'(MAX_EDGES));
	assign n_eff   = (cfg_nodes > KW'(dmlp_pkg::NODE_CAP)) ? KW'(dmlp_pkg::NODE_CAP) : cfg_nodes;
	assign match   = (MW'(let_rd) == MW'(c_q));
	assign su_d    = score_rd + KW'(match);
	assign deg_dec = deg_rd - EW'(1);

	// status to the controller
	assign status.edge_end    = (e_q == etotal_q);
	assign status.node_end    = (i_q == n_q);
	assign status.queue_end   = (head_q == tail_q);
	assign status.head_end    = (head_q == n_q);
	assign status.cyclic      = (tail_q != n_q);
	assign status.last_letter = (c_q == CW'(ALPHABET - 1));
	assign status.out_free    = !out_valid || out_ready;

	// ram port steering
	always_comb begin
		edge_we     = (op == dmlp_pkg::OP_LOAD) && (command == dmlp_pkg::CMD_ADD_EDGE) && !full;
		let_we      = (op == dmlp_pkg::OP_LOAD) && (command == dmlp_pkg::CMD_SET_LETTER);
		deg_we      = 1'b0;
		deg_waddr   = dst_q;
		deg_wdata   = deg_rd + EW'(1);
		deg_raddr   = edge_rd[NW-1:0];
		topo_we     = 1'b0;
		topo_waddr  = tail_q[NW-1:0];
		topo_wdata  = dst_q;
		score_we    = 1'b0;
		score_waddr = dst_q;
		score_wdata = su_q;
		score_raddr = edge_rd[NW-1:0];
		unique case (op)
			dmlp_pkg::OP_CLR_DEG: begin
				deg_we    = 1'b1;
				deg_waddr = i_q[NW-1:0];
				deg_wdata = '0;
			end
			dmlp_pkg::OP_DEG_INC: deg_we = vld_q;
			dmlp_pkg::OP_Q_RD: deg_raddr = i_q[NW-1:0];
			dmlp_pkg::OP_Q_PUSH: begin
				topo_we    = (deg_rd == '0);
				topo_wdata = i_q[NW-1:0];
			end
			dmlp_pkg::OP_K_DEC: begin
				deg_we    = hit_q;
				deg_wdata = deg_dec;
				topo_we   = hit_q && (deg_dec == '0);
			end
			dmlp_pkg::OP_CLR_SCORE: begin
				score_we    = 1'b1;
				score_waddr = i_q[NW-1:0];
				score_wdata = '0;
			end
			dmlp_pkg::OP_P_U: score_raddr = topo_rd;
			dmlp_pkg::OP_SCORE_UPD: score_we = hit_q && (score_rd < su_q);
			default: ;
		endcase
	end

	dmlp_ram #(.WIDTH(2 * NW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(etotal_q[EAW-1:0]), .wdata({node_a, node_b}),
		.raddr(e_q[EAW-1:0]), .rdata(edge_rd)
	);

	dmlp_ram #(.WIDTH(dmlp_pkg::LETTER_W), .DEPTH(dmlp_pkg::NODE_CAP)) u_letter_ram (
		.clk(clk), .we(let_we), .waddr(node_a), .wdata(letter),
		.raddr(topo_rd), .rdata(let_rd)
	);

	dmlp_ram #(.WIDTH(EW), .DEPTH(dmlp_pkg::NODE_CAP)) u_deg_ram (
		.clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
		.raddr(deg_raddr), .rdata(deg_rd)
	);

	dmlp_ram #(.WIDTH(NW), .DEPTH(dmlp_pkg::NODE_CAP)) u_topo_ram (
		.clk(clk), .we(topo_we), .waddr(topo_waddr), .wdata(topo_wdata),
		.raddr(head_q[NW-1:0]), .rdata(topo_rd)
	);

	dmlp_ram #(.WIDTH(KW), .DEPTH(dmlp_pkg::NODE_CAP)) u_score_ram (
		.clk(clk), .we(score_we), .waddr(score_waddr), .wdata(score_wdata),
		.raddr(score_raddr), .rdata(score_rd)
	);

	// edge payload, current node and its score latched for the update steps
	always_ff @(posedge clk) begin
		if (op == dmlp_pkg::OP_DEG_LATCH || op == dmlp_pkg::OP_SCORE_LATCH) begin
			dst_q <= edge_rd[NW-1:0];
			vld_q <= (KW'(edge_rd[2*NW-1:NW]) < n_q) && (KW'(edge_rd[NW-1:0]) < n_q);
			hit_q <= (edge_rd[2*NW-1:NW] == u_q) && (KW'(edge_rd[NW-1:0]) < n_q);
		end
		if (op == dmlp_pkg::OP_K_U || op == dmlp_pkg::OP_P_U) begin
			u_q <= topo_rd;
		end
		if (op == dmlp_pkg::OP_P_S) begin
			su_q <= su_d;
		end
	end

	// counters, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q           <= '0;
			i_q           <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			best_q        <= '0;
			e_q           <= '0;
			etotal_q      <= '0;
			c_q           <= '0;
			ovf_q         <= 1'b0;
			out_valid     <= 1'b0;
			has_cycle     <= 1'b0;
			best_count    <= '0;
			edges_dropped <= 1'b0;
		end else begin
			// result transaction valid
			if (op == dmlp_pkg::OP_FINISH) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (op)
				dmlp_pkg::OP_LOAD: begin
					if (command == dmlp_pkg::CMD_ADD_EDGE) begin
						if (full) ovf_q <= 1'b1;
						else etotal_q <= etotal_q + EW'(1);
					end
				end
				dmlp_pkg::OP_INIT: begin
					n_q    <= n_eff;
					i_q    <= '0;
					e_q    <= '0;
					head_q <= '0;
					tail_q <= '0;
					best_q <= '0;
				end
				dmlp_pkg::OP_CLR_DEG, dmlp_pkg::OP_CLR_SCORE: i_q <= i_q + KW'(1);
				dmlp_pkg::OP_DEG_INC, dmlp_pkg::OP_SCORE_UPD: e_q <= e_q + EW'(1);
				dmlp_pkg::OP_I_ZERO: i_q <= '0;
				dmlp_pkg::OP_Q_PUSH: begin
					if (deg_rd == '0) tail_q <= tail_q + KW'(1);
					i_q <= i_q + KW'(1);
				end
				dmlp_pkg::OP_K_U: begin
					head_q <= head_q + KW'(1);
					e_q    <= '0;
				end
				dmlp_pkg::OP_K_DEC: begin
					if (hit_q && deg_dec == '0) tail_q <= tail_q + KW'(1);
					e_q <= e_q + EW'(1);
				end
				dmlp_pkg::OP_DP_START: begin
					c_q    <= '0;
					i_q    <= '0;
					head_q <= '0;
				end
				dmlp_pkg::OP_NEXT_LETTER: begin
					c_q    <= c_q + CW'(1);
					i_q    <= '0;
					head_q <= '0;
				end
				dmlp_pkg::OP_P_S: begin
					if (su_d > best_q) best_q <= su_d;
					head_q <= head_q + KW'(1);
					e_q    <= '0;
				end
				dmlp_pkg::OP_FINISH: begin
					has_cycle     <= status.cyclic;
					best_count    <= status.cyclic ? '0 : best_q;
					edges_dropped <= ovf_q;
					etotal_q      <= '0;
					ovf_q         <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/dmlp_checker.sv @@
// dmlp_checker: port level assertions for dag_max_label_path, bound to it
// depends on dmlp_pkg for the command codes
`timescale 1ns / 1ps

module dmlp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] command,
	input logic       out_valid,
	input logic       out_ready,
	input logic       has_cycle,
	input logic [8:0] best_count,
	input logic       edges_dropped
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_count)
		&& $stable(has_cycle) && $stable(edges_dropped))
		else $error("result changed while stalled");

	// cyclic graph reports zero count
	a_cycle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_cycle |-> best_count == 9'd0)
		else $error("nonzero count on cyclic graph");

	// count never exceeds node capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_count <= 9'd256)
		else $error("count beyond node capacity");

	// run transaction starts the walk and blocks input
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == dmlp_pkg::CMD_RUN |=> !in_ready)
		else $error("input taken right after run");

endmodule

bind dag_max_label_path dmlp_checker u_dmlp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.command(command), .out_valid(out_valid), .out_ready(out_ready),
	.has_cycle(has_cycle), .best_count(best_count), .edges_dropped(edges_dropped)
);

@@ sim/tb_dag_max_label_path.sv @@
// tb_dag_max_label_path: self-checking testbench of the dag label path block
// random and directed graph loads with runs, checked against an in-bench predictor
// depends on dmlp_pkg and dag_max_label_path
`timescale 1ns / 1ps

module tb_dag_max_label_path;

	localparam int EDGE_CAP   = 1024;
	localparam int LETTERS    = 26;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int ITEM_TARGET = 1450;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] a;
		logic [7:0] b;
		logic [4:0] ltr;
	} graph_item_t;

	typedef struct packed {
		logic       cyc;
		logic [8:0] best;
		logic       drop;
	} run_report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [1:0]  command;
	logic [7:0]  node_a, node_b;
	logic [4:0]  letter;
	logic        out_valid, out_ready;
	logic        has_cycle;
	logic [8:0]  best_count;
	logic        edges_dropped;

	dag_max_label_path u_dut (.*);

	// shadow of the block state
	logic [4:0]  node_letter_sh [256];
	logic [7:0]  edge_src_sh [EDGE_CAP];
	logic [7:0]  edge_dst_sh [EDGE_CAP];
	int          edge_fill_sh = 0;
	bit          overflow_sh = 1'b0;
	int unsigned node_count_sh;

	graph_item_t pending_items[$];
	run_report_t expected_reports[$];
	int          fail_count = 0;
	int unsigned cycle_count = 0;
	int          item_total = 0;
	bit          no_idle;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		fail_count++;
	endtask

	// kahn ordering then per-letter longest path scoring
	function automatic run_report_t score_graph(input int unsigned n_in);
		int unsigned n;
		int          indeg [256];
		int          order [256];
		int          score [256];
		int          head, tail, u, v, e, c, best;
		run_report_t r;
		n = (n_in > 256) ? 256 : n_in;
		for (int i = 0; i < 256; i++) indeg[i] = 0;
		for (e = 0; e < edge_fill_sh; e++)
			if (edge_src_sh[e] < n && edge_dst_sh[e] < n) indeg[edge_dst_sh[e]]++;
		tail = 0;
		for (u = 0; u < n; u++)
			if (indeg[u] == 0) begin
				order[tail] = u;
				tail++;
			end
		head = 0;
		while (head < tail) begin
			u = order[head];
			head++;
			for (e = 0; e < edge_fill_sh; e++)
				if (edge_src_sh[e] == u && edge_dst_sh[e] < n) begin
					v = edge_dst_sh[e];
					indeg[v]--;
					if (indeg[v] == 0) begin
						order[tail] = v;
						tail++;
					end
				end
		end
		r.drop = overflow_sh;
		if (tail < n) begin
			r.cyc = 1'b1;
			r.best = '0;
			return r;
		end
		best = 0;
		for (c = 0; c < LETTERS; c++) begin
			for (int i = 0; i < 256; i++) score[i] = 0;
			for (head = 0; head < n; head++) begin
				u = order[head];
				if (node_letter_sh[u] == c) score[u]++;
				if (score[u] > best) best = score[u];
				for (e = 0; e < edge_fill_sh; e++)
					if (edge_src_sh[e] == u && edge_dst_sh[e] < n) begin
						v = edge_dst_sh[e];
						if (score[v] < score[u]) score[v] = score[u];
					end
			end
		end
		r.cyc = 1'b0;
		r.best = (best > 511) ? 9'd511 : best[8:0];
		return r;
	endfunction

	// apply one accepted transaction to the shadow state
	task automatic apply_item(input graph_item_t it);
		case (it.cmd)
			dmlp_pkg::CMD_SET_LETTER: node_letter_sh[it.a] = it.ltr;
			dmlp_pkg::CMD_ADD_EDGE: begin
				if (edge_fill_sh < EDGE_CAP) begin
					edge_src_sh[edge_fill_sh] = it.a;
					edge_dst_sh[edge_fill_sh] = it.b;
					edge_fill_sh++;
				end else overflow_sh = 1'b1;
			end
			dmlp_pkg::CMD_RUN: begin
				expected_reports = {expected_reports, score_graph(node_count_sh)};
				edge_fill_sh = 0;
				overflow_sh = 1'b0;
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// driver
	int          in_gap;
	graph_item_t cur_item;
	always @(posedge clk or negedge arst_n) begin
		bit accepted;
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= '0;
			node_a <= '0;
			node_b <= '0;
			letter <= '0;
			in_gap = 0;
		end else begin
			accepted = in_valid && in_ready;
			if (accepted) apply_item(cur_item);
			if (!in_valid || accepted) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					command <= cur_item.cmd;
					node_a <= cur_item.a;
					node_b <= cur_item.b;
					letter <= cur_item.ltr;
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else in_valid <= 1'b0;
			end
		end
	end

	// monitor and result sink stalls
	int out_gap;
	always @(posedge clk or negedge arst_n) begin
		run_report_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_reports.pop_front();
					if (has_cycle !== want.cyc)
						report_mismatch("has_cycle", has_cycle, want.cyc);
					if (best_count !== want.best)
						report_mismatch("best_count", best_count, want.best);
					if (edges_dropped !== want.drop)
						report_mismatch("edges_dropped", edges_dropped, want.drop);
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap = pick_gap();
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == {dmlp_pkg::REG_NODE_COUNT, 2'b00}) node_count_sh = data[8:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || expected_reports.size() > 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic queue_item(input logic [1:0] c, input int a, input int b, input int l);
		graph_item_t it;
		it.cmd = c;
		it.a = 8'(a);
		it.b = 8'(b);
		it.ltr = 5'(l);
		pending_items = {pending_items, it};
		item_total++;
	endtask

	initial begin
		int n, k, nedge;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		node_count_sh = dmlp_pkg::NODE_COUNT_RESET;
		no_idle = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every node gets a letter, some beyond the alphabet
		for (int i = 0; i < 256; i++)
			queue_item(dmlp_pkg::CMD_SET_LETTER, i, $urandom_range(0, 255), i % 32);
		wait_idle();

		// full node count, one long edge
		cfg_write({dmlp_pkg::REG_NODE_COUNT, 2'b00}, 256);
		queue_item(dmlp_pkg::CMD_ADD_EDGE, 255, 0, 0);
		queue_item(CMD_UNUSED, 255, 255, 31);
		queue_item(dmlp_pkg::CMD_RUN, 0, 0, 0);
		wait_idle();

		// self-loop on a single node
		cfg_write({dmlp_pkg::REG_NODE_COUNT, 2'b00}, 1);
		queue_item(dmlp_pkg::CMD_ADD_EDGE, 0, 0, 31);
		queue_item(dmlp_pkg::CMD_RUN, 255, 255, 31);
		// chain of equal letters
		wait_idle();
		cfg_write({dmlp_pkg::REG_NODE_COUNT, 2'b00}, 4);
		for (int i = 0; i < 4; i++) queue_item(dmlp_pkg::CMD_SET_LETTER, i, 0, 25);
		for (int i = 0; i < 3; i++) queue_item(dmlp_pkg::CMD_ADD_EDGE, i, i + 1, 0);
		queue_item(dmlp_pkg::CMD_ADD_EDGE, 2, 200, 0);
		queue_item(dmlp_pkg::CMD_RUN, 0, 0, 0);
		wait_idle();

		// empty graph and count above capacity
		cfg_write({dmlp_pkg::REG_NODE_COUNT, 2'b00}, 0);
		queue_item(dmlp_pkg::CMD_RUN, 0, 0, 0);
		wait_idle();
		cfg_write({dmlp_pkg::REG_NODE_COUNT, 2'b00}, 511);
		queue_item(dmlp_pkg::CMD_RUN, 0, 0, 0);
		wait_idle();

		// store overflow
		cfg_write({dmlp_pkg::REG_NODE_COUNT, 2'b00}, 1);
		for (int i = 0; i < EDGE_CAP + 3; i++)
			queue_item(dmlp_pkg::CMD_ADD_EDGE, $urandom_range(1, 255), $urandom_range(0, 255), 0);
		queue_item(dmlp_pkg::CMD_RUN, 0, 0, 0);
		queue_item(dmlp_pkg::CMD_RUN, 0, 0, 0);
		wait_idle();

		// random graphs, mostly acyclic with small sizes
		while (item_total < ITEM_TARGET) begin
			n = $urandom_range(2, 8);
			no_idle = ($urandom_range(0, 5) == 0);
			cfg_write({dmlp_pkg::REG_NODE_COUNT, 2'b00}, n);
			for (k = 0; k < $urandom_range(0, 4); k++) begin
				if ($urandom_range(0, 3) == 0)
					queue_item(dmlp_pkg::CMD_SET_LETTER, $urandom_range(0, 255), $urandom,
						$urandom_range(0, 31));
				else
					queue_item(dmlp_pkg::CMD_SET_LETTER, $urandom_range(0, n - 1), $urandom,
						$urandom_range(0, 3));
			end
			nedge = $urandom_range(0, 8);
			for (k = 0; k < nedge; k++) begin
				case ($urandom_range(0, 19))
					0: queue_item(dmlp_pkg::CMD_ADD_EDGE, $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom);
					1, 2: queue_item(dmlp_pkg::CMD_ADD_EDGE, $urandom_range(0, n - 1),
						$urandom_range(0, n - 1), $urandom);
					3: queue_item(CMD_UNUSED, $urandom, $urandom, $urandom);
					default: begin
						int s;
						s = $urandom_range(0, n - 2);
						queue_item(dmlp_pkg::CMD_ADD_EDGE, s, $urandom_range(s + 1, n - 1),
							$urandom);
					end
				endcase
			end
			queue_item(dmlp_pkg::CMD_RUN, $urandom, $urandom, $urandom);
			wait_idle();
		end
		no_idle = 1'b0;

		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_reports.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/dmlp_pkg.sv
hdl/dmlp_ram.sv
hdl/dmlp_ctrl.sv
hdl/dmlp_datapath.sv
hdl/dag_max_label_path.sv
hdl/dmlp_checker.sv
sim/tb_dag_max_label_path.sv
